// File: hdl/t9ksm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9ksm_pkg
// Shared types, codes and the keypad digit map for the T9 contact matcher.
// ----------------------------------------------------------------------------
package t9ksm_pkg;

  localparam int MAX_QUERY  = 16;
  localparam int MAX_LINE   = 100;
  localparam int DIGIT_W    = 4;
  localparam int QUERY_W    = MAX_QUERY * DIGIT_W;
  localparam int QLEN_W     = 5;
  localparam int LINE_W     = 7;
  localparam int INDEX_W    = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_PLUS    = 8'd43;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_NINE    = 8'd57;
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

  localparam logic [DIGIT_W-1:0] NO_DIGIT = 4'd15;

  localparam logic [CFG_IDX_W-1:0] REG_QUERY_DIGITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_LENGTH = 1'd1;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [1:0] {
    KIND_RECORD   = 2'd0,
    KIND_TOO_LONG = 2'd1,
    KIND_SUMMARY  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [INDEX_W-1:0] record_index;
    logic               matched;
    logic               any_found;
  } result_t;

  localparam logic [DIGIT_W-1:0] KEYPAD [26] = '{
    4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd6,
    4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd9, 4'd9, 4'd9, 4'd9
  };

  // Keypad digit of a byte; NO_DIGIT for anything that matches nothing.
  function automatic logic [DIGIT_W-1:0] to_digit(input logic [7:0] c,
                                                  input logic number_line);
    logic [7:0]         up_off;
    logic [7:0]         lo_off;
    logic [DIGIT_W-1:0] d;
    up_off = c - CHAR_UPPER_A;
    lo_off = c - CHAR_LOWER_A;
    d      = NO_DIGIT;
    if (c == CHAR_PLUS) begin
      d = '0;
    end else if (number_line) begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        d = DIGIT_W'(c - CHAR_ZERO);
      end
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d = KEYPAD[up_off[4:0]];
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      d = KEYPAD[lo_off[4:0]];
    end
    return d;
  endfunction

endpackage

// File: hdl/t9ksm_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9ksm channel interfaces
// Valid/ready channels for stream bytes in and match results out.
// ----------------------------------------------------------------------------
interface t9ksm_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] char_byte;

  modport source (output valid, output op, output char_byte, input ready);
  modport sink   (input valid, input op, input char_byte, output ready);
endinterface

interface t9ksm_out_if;
  t9ksm_pkg::kind_t                       kind;
  logic                                   valid;
  logic                                   ready;
  logic [t9ksm_pkg::INDEX_W-1:0]          record_index;
  logic                                   matched;
  logic                                   any_found;

  modport source (output valid, output kind, output record_index, output matched,
                  output any_found, input ready);
  modport sink   (input valid, input kind, input record_index, input matched,
                  input any_found, output ready);
endinterface

// File: hdl/t9_keypad_substring_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9_keypad_substring_match
// T9 contact search: keypad-digit substring match over name/number records.
// ----------------------------------------------------------------------------
// Each accepted request is one byte of the contact list (or an end-of-input
// marker) and is handled in the cycle it is taken: one request per clock
// while ready is high, set by the shift-and update of the 16-bit match vector. A
// number line's newline yields a record result; end of input yields an
// optional last record plus the summary, then the block halts until reset,
// still taking requests but producing nothing. Results go through a
// four-entry queue; input ready drops only while that queue holds more than
// two results. The query registers may only be written while idle.
module t9_keypad_substring_match (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [t9ksm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [t9ksm_pkg::CFG_DATA_W-1:0]       cfg_data,
  t9ksm_in_if.sink                               in_ch,
  t9ksm_out_if.source                            out_ch
);
  import t9ksm_pkg::*;

  logic [QUERY_W-1:0]   query_digits;
  logic [QLEN_W-1:0]    query_length;

  logic [MAX_QUERY-1:0] match_vec;
  logic                 name_matched;
  logic                 number_matched;
  logic                 on_number_line;
  logic [LINE_W-1:0]    line_length;
  logic [INDEX_W-1:0]   record_count;
  logic                 found_flag;
  logic                 halted;

  logic [MAX_QUERY-1:0] match_vec_next;
  logic                 name_matched_next;
  logic                 number_matched_next;
  logic                 on_number_line_next;
  logic [LINE_W-1:0]    line_length_next;
  logic [INDEX_W-1:0]   record_count_next;
  logic                 found_flag_next;
  logic                 halted_next;

  logic                 accept;
  logic [QLEN_W-1:0]    eff_len;
  logic                 len_zero;
  logic [DIGIT_W-1:0]   digit;
  logic [MAX_QUERY-1:0] digit_mask;
  logic [MAX_QUERY-1:0] shifted_vec;
  logic [3:0]           tail_bit;
  logic                 line_hit;
  logic                 rec_matched;
  logic                 rec_found;

  logic                 push_first;
  logic                 push_second;
  result_t              first_data;
  result_t              second_data;
  logic                 room_for_two;
  result_t              out_data;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = room_for_two;

  assign eff_len  = (query_length > QLEN_W'(MAX_QUERY)) ? QLEN_W'(MAX_QUERY) : query_length;
  assign len_zero = (eff_len == '0);
  assign digit    = to_digit(in_ch.char_byte, on_number_line);
  assign tail_bit = 4'(eff_len - QLEN_W'(1));

  always_comb begin
    for (int i = 0; i < MAX_QUERY; i++) begin
      digit_mask[i] = (QLEN_W'(i) < eff_len) && (digit != NO_DIGIT) &&
                      (query_digits[DIGIT_W*i +: DIGIT_W] == digit);
    end
  end

  assign shifted_vec = {match_vec[MAX_QUERY-2:0], 1'b1} & digit_mask;
  assign line_hit    = !len_zero && shifted_vec[tail_bit];

  // Record outcome if this request closes a number line
  assign rec_matched = name_matched || number_matched || len_zero;
  assign rec_found   = found_flag || rec_matched;

  always_comb begin
    match_vec_next      = match_vec;
    name_matched_next   = name_matched;
    number_matched_next = number_matched;
    on_number_line_next = on_number_line;
    line_length_next    = line_length;
    record_count_next   = record_count;
    found_flag_next     = found_flag;
    halted_next         = halted;
    push_first          = 1'b0;
    push_second         = 1'b0;
    first_data          = '{kind: KIND_RECORD, record_index: record_count,
                            matched: rec_matched, any_found: rec_found};
    second_data         = '{kind: KIND_SUMMARY, record_index: record_count + 16'd1,
                            matched: 1'b0, any_found: rec_found};

    if (accept && !halted) begin
      priority if (in_ch.op == OP_END) begin
        halted_next = 1'b1;
        if (on_number_line && line_length != '0) begin
          push_first          = 1'b1;
          push_second         = 1'b1;
          found_flag_next     = rec_found;
          record_count_next   = record_count + 16'd1;
          name_matched_next   = 1'b0;
          number_matched_next = 1'b0;
        end else begin
          push_first = 1'b1;
          first_data = '{kind: KIND_SUMMARY, record_index: record_count,
                         matched: 1'b0, any_found: found_flag || len_zero};
        end
      end else if (in_ch.char_byte == CHAR_NEWLINE) begin
        if (on_number_line) begin
          push_first          = 1'b1;
          found_flag_next     = rec_found;
          record_count_next   = record_count + 16'd1;
          name_matched_next   = 1'b0;
          number_matched_next = 1'b0;
        end
        match_vec_next      = '0;
        line_length_next    = '0;
        on_number_line_next = !on_number_line;
      end else if (line_length >= LINE_W'(MAX_LINE)) begin
        push_first  = 1'b1;
        halted_next = 1'b1;
        first_data  = '{kind: KIND_TOO_LONG, record_index: record_count,
                        matched: 1'b0, any_found: found_flag || len_zero};
      end else begin
        line_length_next = line_length + LINE_W'(1);
        match_vec_next   = shifted_vec;
        if (line_hit) begin
          if (on_number_line) begin
            number_matched_next = 1'b1;
          end else begin
            name_matched_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_digits   <= '0;
      query_length   <= '0;
      match_vec      <= '0;
      name_matched   <= 1'b0;
      number_matched <= 1'b0;
      on_number_line <= 1'b0;
      line_length    <= '0;
      record_count   <= '0;
      found_flag     <= 1'b0;
      halted         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_QUERY_DIGITS: query_digits <= cfg_data[QUERY_W-1:0];
          REG_QUERY_LENGTH: query_length <= cfg_data[QLEN_W-1:0];
          default: ;
        endcase
      end
      match_vec      <= match_vec_next;
      name_matched   <= name_matched_next;
      number_matched <= number_matched_next;
      on_number_line <= on_number_line_next;
      line_length    <= line_length_next;
      record_count   <= record_count_next;
      found_flag     <= found_flag_next;
      halted         <= halted_next;
    end
  end

  t9ksm_result_fifo u_result_fifo (
    .clk          (clk),
    .rst          (rst),
    .push_first   (push_first),
    .push_second  (push_second),
    .first_data   (first_data),
    .second_data  (second_data),
    .room_for_two (room_for_two),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_data     (out_data)
  );

  assign out_ch.kind         = out_data.kind;
  assign out_ch.record_index = out_data.record_index;
  assign out_ch.matched      = out_data.matched;
  assign out_ch.any_found    = out_data.any_found;
endmodule

// File: hdl/t9ksm_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9ksm_result_fifo
// Four-entry result queue taking up to two results per cycle, one out.
// ----------------------------------------------------------------------------
module t9ksm_result_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_first,
  input  logic                push_second,
  input  t9ksm_pkg::result_t  first_data,
  input  t9ksm_pkg::result_t  second_data,
  output logic                room_for_two,
  output logic                out_valid,
  input  logic                out_ready,
  output t9ksm_pkg::result_t  out_data
);
  import t9ksm_pkg::*;

  result_t    entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic [1:0] wr_ptr_next;
  logic       pop;

  assign pop          = out_valid && out_ready;
  assign out_valid    = (count != 3'd0);
  assign out_data     = entries[rd_ptr];
  assign room_for_two = (count <= 3'd2);

  always_comb begin
    count_next  = count + {2'b0, push_first} + {2'b0, push_second} - {2'b0, pop};
    wr_ptr_next = wr_ptr + {1'b0, push_first} + {1'b0, push_second};
  end

  always_ff @(posedge clk) begin
    if (push_first) begin
      entries[wr_ptr] <= first_data;
    end
    if (push_second) begin
      entries[wr_ptr + 2'd1] <= second_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
    end
  end
endmodule
